@@ design/lmrr_pkg.sv @@
// ----------------------------------------------------------------------------
// lmrr_pkg
// Shared constants, codes and types of the revoke/retry lock manager.
// ----------------------------------------------------------------------------
package lmrr_pkg;

    // table geometry
    localparam int LOCK_COUNT  = 64;
    localparam int QUEUE_DEPTH = 8;
    localparam int HOST_COUNT  = 16;

    // field widths
    localparam int CMD_W  = 1;
    localparam int LOCK_W = 6;
    localparam int HOST_W = 4;
    localparam int STAT_W = 2;
    localparam int KIND_W = 2;

    // derived widths
    localparam int HEAD_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int FIFO_N  = LOCK_COUNT * QUEUE_DEPTH;
    localparam int FIFO_AW = $clog2(FIFO_N);

    typedef enum logic [CMD_W-1:0] {
        CMD_ACQUIRE = 1'b0,
        CMD_RELEASE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_FREE     = 2'd0,
        MODE_HELD     = 2'd1,
        MODE_REVOKING = 2'd2,
        MODE_RETRYING = 2'd3
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_RETRY    = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef enum logic [KIND_W-1:0] {
        MSG_NONE   = 2'd0,
        MSG_REVOKE = 2'd1,
        MSG_RETRY  = 2'd2
    } t_msg;

    // one lock table entry
    typedef struct packed {
        t_mode               mode;
        logic [HOST_W-1:0]   holder;
        logic [HOST_W-1:0]   invited;
        logic [HEAD_W-1:0]   head;
        logic [CNT_W-1:0]    count;
    } t_entry;

    // lock table read request
    typedef struct packed {
        logic              en;
        logic [LOCK_W-1:0] addr;
    } t_tbl_rd;

    // lock table write request
    typedef struct packed {
        logic              en;
        logic [LOCK_W-1:0] addr;
        t_entry            data;
    } t_tbl_wr;

endpackage

@@ design/lmrr_if.sv @@
// ----------------------------------------------------------------------------
// lmrr_if
// Valid/ready channels of the lock manager: request and reply.
// ----------------------------------------------------------------------------
interface lmrr_req_if;
    logic                        valid;
    logic                        ready;
    logic [lmrr_pkg::CMD_W-1:0]  command;
    logic [lmrr_pkg::LOCK_W-1:0] lock_index;
    logic [lmrr_pkg::HOST_W-1:0] requester_host;

    modport source (output valid, command, lock_index, requester_host, input ready);
    modport sink   (input valid, command, lock_index, requester_host, output ready);
endinterface

interface lmrr_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [lmrr_pkg::STAT_W-1:0] reply_status;
    logic [lmrr_pkg::KIND_W-1:0] message_kind;
    logic [lmrr_pkg::HOST_W-1:0] message_host;

    modport source (output valid, reply_status, message_kind, message_host, input ready);
    modport sink   (input valid, reply_status, message_kind, message_host, output ready);
endinterface

@@ design/lmrr_lock_table.sv @@
// ----------------------------------------------------------------------------
// lmrr_lock_table
// Per-lock entry memory, one read and one write port, registered read data.
// Valid bits make never-written entries read as free with an empty queue.
// ----------------------------------------------------------------------------
module lmrr_lock_table (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lmrr_pkg::t_tbl_rd i_rd,
    output lmrr_pkg::t_entry  o_rd_data,
    input  lmrr_pkg::t_tbl_wr i_wr
);
    import lmrr_pkg::*;

    t_entry                  r_mem [LOCK_COUNT];
    logic [LOCK_COUNT-1:0]   r_valid;
    t_entry                  r_rd_data;
    logic                    r_rd_hit;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    // written-entry flags and registered hit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd.en) begin
                r_rd_hit <= r_valid[i_rd.addr];
            end
        end
    end

    // unwritten entries read as the reset entry
    always_comb begin
        o_rd_data = r_rd_data;
        if (!r_rd_hit) begin
            o_rd_data.mode  = MODE_FREE;
            o_rd_data.head  = '0;
            o_rd_data.count = '0;
        end
    end

endmodule

@@ design/lock_manager_revoke_retry.sv @@
// A request's lock table read is registered; the lookup step then loads the
// reply beat or, for a release that pops a waiter, reads the wait queue after the
// lock table read and loads the reply beat in the pop step. Both steps wait
// while a held reply beat is not taken; a new request waits for the reply load.
// Reset: all locks free with empty queues at once (per-entry valid bits); no
// clearing pass, requests are taken in the first cycle after reset.
// ----------------------------------------------------------------------------
// lock_manager_revoke_retry
// Caching lock server with revoke and retry messages. Lock entries and the
// per-lock wait queues live in synchronous memories; each request reads its
// lock entry once and writes it back at most once.
// ----------------------------------------------------------------------------
module lock_manager_revoke_retry (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lmrr_req_if.sink   i_req,
    lmrr_rsp_if.source o_rsp
);
    import lmrr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOOK = 3'b010,
        S_POP  = 3'b100
    } t_state;

    t_state             r_state, n_state;
    t_cmd               r_cmd;
    logic [LOCK_W-1:0]  r_lock;
    logic [HOST_W-1:0]  r_host;

    logic               r_rsp_valid, n_rsp_valid;
    t_status            r_status, n_status;
    t_msg               r_kind, n_kind;
    logic [HOST_W-1:0]  r_dest, n_dest;
    logic               rsp_load;

    t_tbl_rd            tbl_rd;
    t_tbl_wr            tbl_wr;
    t_entry             rd;

    logic [HOST_W-1:0]  r_fifo [FIFO_N];
    logic [HOST_W-1:0]  r_fifo_rd;
    logic               fifo_we, fifo_re;
    logic [FIFO_AW-1:0] fifo_wa, fifo_ra;

    logic               accept, out_free, push_ok, do_push;
    logic [CNT_W:0]     tail_sum;
    logic [CNT_W:0]     tail_wrap;
    logic [HEAD_W-1:0]  tail_slot;
    logic [HEAD_W:0]    head_inc;
    logic [HEAD_W-1:0]  head_next;
    logic [FIFO_AW-1:0] lock_base;

    assign accept       = i_req.valid && i_req.ready;
    assign i_req.ready  = (r_state == S_IDLE);
    assign out_free     = !r_rsp_valid || o_rsp.ready;

    assign o_rsp.valid        = r_rsp_valid;
    assign o_rsp.reply_status = r_status;
    assign o_rsp.message_kind = r_kind;
    assign o_rsp.message_host = r_dest;

    // lock table
    assign tbl_rd.en   = accept;
    assign tbl_rd.addr = i_req.lock_index;

    lmrr_lock_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd      (tbl_rd),
        .o_rd_data (rd),
        .i_wr      (tbl_wr)
    );

    // queue slot arithmetic
    assign push_ok   = (rd.count < CNT_W'(QUEUE_DEPTH));
    assign tail_sum  = (CNT_W+1)'(rd.head) + (CNT_W+1)'(rd.count);
    assign tail_wrap = (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH))
                     ? tail_sum - (CNT_W+1)'(QUEUE_DEPTH) : tail_sum;
    assign tail_slot = tail_wrap[HEAD_W-1:0];
    assign head_inc  = (HEAD_W+1)'(rd.head) + (HEAD_W+1)'(1);
    assign head_next = (head_inc == (HEAD_W+1)'(QUEUE_DEPTH))
                     ? '0 : head_inc[HEAD_W-1:0];
    assign lock_base = FIFO_AW'(r_lock * QUEUE_DEPTH);
    assign fifo_wa   = lock_base + FIFO_AW'(tail_slot);
    assign fifo_ra   = lock_base + FIFO_AW'(rd.head);

    // request decode and entry update
    always_comb begin
        n_state     = r_state;
        tbl_wr.en   = 1'b0;
        tbl_wr.addr = r_lock;
        tbl_wr.data = rd;
        fifo_we     = 1'b0;
        fifo_re     = 1'b0;
        do_push     = 1'b0;
        rsp_load    = 1'b0;
        n_status    = ST_OK;
        n_kind      = MSG_NONE;
        n_dest      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (out_free) begin
                    if (r_cmd == CMD_RELEASE && rd.count != '0) begin
                        fifo_re = 1'b1;
                        n_state = S_POP;
                    end else begin
                        rsp_load = 1'b1;
                        n_state  = S_IDLE;
                        if (r_cmd == CMD_RELEASE) begin
                            tbl_wr.en        = 1'b1;
                            tbl_wr.data.mode = MODE_FREE;
                        end else begin
                            unique case (rd.mode)
                                MODE_FREE: begin
                                    tbl_wr.en          = 1'b1;
                                    tbl_wr.data.mode   = MODE_HELD;
                                    tbl_wr.data.holder = r_host;
                                end
                                MODE_HELD: begin
                                    if (push_ok) begin
                                        do_push          = 1'b1;
                                        tbl_wr.data.mode = MODE_REVOKING;
                                        n_status         = ST_RETRY;
                                        n_kind           = MSG_REVOKE;
                                        n_dest           = rd.holder;
                                    end else begin
                                        n_status = ST_OVERFLOW;
                                    end
                                end
                                MODE_REVOKING: begin
                                    do_push  = push_ok;
                                    n_status = push_ok ? ST_RETRY : ST_OVERFLOW;
                                end
                                MODE_RETRYING: begin
                                    if (r_host != rd.invited) begin
                                        do_push  = push_ok;
                                        n_status = push_ok ? ST_RETRY : ST_OVERFLOW;
                                    end else begin
                                        tbl_wr.en          = 1'b1;
                                        tbl_wr.data.holder = r_host;
                                        if (rd.count != '0) begin
                                            tbl_wr.data.mode = MODE_REVOKING;
                                            n_kind           = MSG_REVOKE;
                                            n_dest           = r_host;
                                        end else begin
                                            tbl_wr.data.mode = MODE_HELD;
                                        end
                                    end
                                end
                                default: begin
                                    n_status = ST_OK;
                                end
                            endcase
                            // enqueue the requester
                            if (do_push) begin
                                tbl_wr.en         = 1'b1;
                                tbl_wr.data.count = rd.count + CNT_W'(1);
                                fifo_we           = 1'b1;
                            end
                        end
                    end
                end
            end
            S_POP: begin
                if (out_free) begin
                    tbl_wr.en           = 1'b1;
                    tbl_wr.data.mode    = MODE_RETRYING;
                    tbl_wr.data.invited = r_fifo_rd;
                    tbl_wr.data.head    = head_next;
                    tbl_wr.data.count   = rd.count - CNT_W'(1);
                    rsp_load            = 1'b1;
                    n_kind              = MSG_RETRY;
                    n_dest              = r_fifo_rd;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_rsp_valid = rsp_load || (r_rsp_valid && !o_rsp.ready);
    end

    // wait queue memory
    always_ff @(posedge i_clk) begin
        if (fifo_we) begin
            r_fifo[fifo_wa] <= r_host;
        end
        if (fifo_re) begin
            r_fifo_rd <= r_fifo[fifo_ra];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    // request capture and reply beat payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= t_cmd'(i_req.command);
            r_lock <= i_req.lock_index;
            r_host <= i_req.requester_host;
        end
        if (rsp_load) begin
            r_status <= n_status;
            r_kind   <= n_kind;
            r_dest   <= n_dest;
        end
    end

    // a reply beat appears only out of a table or queue step
    a_rsp_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_rsp_valid) |-> ($past(r_state) == S_LOOK || $past(r_state) == S_POP))
        else $error("reply beat raised outside a lookup step");

    // a pop is only started on a non-empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> (rd.count != '0))
        else $error("pop step with empty wait queue");

    // the queue fill never passes its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_wr.en |-> (tbl_wr.data.count <= CNT_W'(QUEUE_DEPTH)))
        else $error("wait queue count beyond depth");

    // queue writes and reads never share a cycle
    a_fifo_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fifo_we && fifo_re))
        else $error("wait queue read and write in the same cycle");

endmodule

@@ bench/lock_manager_revoke_retry_tb.sv @@
// ----------------------------------------------------------------------------
// lock_manager_revoke_retry_tb
// Self-checking bench for the revoke/retry lock manager. Acquire and release
// requests go in on the request channel, and a scoreboard keeps its own copy
// of every lock's mode, holder, invited host and wait queue. From that copy
// it predicts each reply and compares it with what comes out. A short
// directed run covers grant, revoke, queue fill and overflow, retry hand-off
// and free. A long random run then works a few hot locks with mostly
// well-formed traffic, and both channels idle at random.
// ----------------------------------------------------------------------------
module lock_manager_revoke_retry_tb;
    import lmrr_pkg::*;

    // expected reply beat
    typedef struct {
        logic [STAT_W-1:0] status;
        logic [KIND_W-1:0] kind;
        logic [HOST_W-1:0] host;
    } t_reply;

    // lock table shadow and pending replies
    class lock_reply_board;
        t_mode             mode    [LOCK_COUNT];
        logic [HOST_W-1:0] holder  [LOCK_COUNT];
        logic [HOST_W-1:0] invited [LOCK_COUNT];
        logic [HOST_W-1:0] waiters [LOCK_COUNT][$];
        t_reply            pending [$];
        int                errors;

        function new();
            for (int i = 0; i < LOCK_COUNT; i++) begin
                mode[i]    = MODE_FREE;
                holder[i]  = '0;
                invited[i] = '0;
            end
            errors = 0;
        endfunction

        // queue a waiter, returns retry or overflow
        function logic [STAT_W-1:0] enqueue(int lk, logic [HOST_W-1:0] h);
            if (waiters[lk].size() >= QUEUE_DEPTH)
                return ST_OVERFLOW;
            waiters[lk].push_back(h);
            return ST_RETRY;
        endfunction

        // accepted request beat: update shadow, record the expected reply
        function void note_request(t_cmd c, logic [LOCK_W-1:0] lock_sel,
                                   logic [HOST_W-1:0] h);
            t_reply r;
            int     lk;
            lk       = int'(lock_sel);
            r.status = ST_OK;
            r.kind   = MSG_NONE;
            r.host   = '0;
            if (c == CMD_ACQUIRE) begin
                case (mode[lk])
                    MODE_FREE: begin
                        mode[lk]   = MODE_HELD;
                        holder[lk] = h;
                    end
                    MODE_HELD: begin
                        r.status = enqueue(lk, h);
                        if (r.status == ST_RETRY) begin
                            mode[lk] = MODE_REVOKING;
                            r.kind   = MSG_REVOKE;
                            r.host   = holder[lk];
                        end
                    end
                    MODE_REVOKING: begin
                        r.status = enqueue(lk, h);
                    end
                    default: begin
                        if (h != invited[lk]) begin
                            r.status = enqueue(lk, h);
                        end else begin
                            holder[lk] = h;
                            if (waiters[lk].size() != 0) begin
                                // new holder must hand it back right away
                                mode[lk] = MODE_REVOKING;
                                r.kind   = MSG_REVOKE;
                                r.host   = h;
                            end else begin
                                mode[lk] = MODE_HELD;
                            end
                        end
                    end
                endcase
            end else begin
                if (waiters[lk].size() == 0) begin
                    mode[lk] = MODE_FREE;
                end else begin
                    // oldest waiter gets the retry invitation
                    invited[lk] = waiters[lk].pop_front();
                    mode[lk]    = MODE_RETRYING;
                    r.kind      = MSG_RETRY;
                    r.host      = invited[lk];
                end
            end
            pending.push_back(r);
        endfunction

        // accepted reply beat: compare with the oldest expectation
        function void check_reply(logic [STAT_W-1:0] st, logic [KIND_W-1:0] kd,
                                  logic [HOST_W-1:0] hs);
            t_reply r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected reply status=%0d kind=%0d host=%0d",
                         $time, st, kd, hs);
                errors++;
                return;
            end
            r = pending.pop_front();
            if (st !== r.status) begin
                $display("%0t: reply_status expected %0d actual %0d", $time, r.status, st);
                errors++;
            end
            if (kd !== r.kind) begin
                $display("%0t: message_kind expected %0d actual %0d", $time, r.kind, kd);
                errors++;
            end
            if (hs !== r.host) begin
                $display("%0t: message_host expected %0d actual %0d", $time, r.host, hs);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    lmrr_req_if req_ch ();
    lmrr_rsp_if rsp_ch ();

    lock_manager_revoke_retry i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    lock_reply_board board;

    // traffic shaping knobs
    bit                src_idle;
    bit                snk_idle;
    int                acq_weight;
    logic [LOCK_W-1:0] hot_lock [4];

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // one request beat, returns right after the accepting edge
    task automatic send_request(input t_cmd c, input logic [LOCK_W-1:0] lk,
                                input logic [HOST_W-1:0] h);
        int gap;
        gap = src_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.command        <= c;
        req_ch.lock_index     <= lk;
        req_ch.requester_host <= h;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        board.note_request(c, lk, h);
    endtask

    // random request, biased toward hot locks and proper hand-offs
    task automatic send_random();
        logic [LOCK_W-1:0] lk;
        logic [HOST_W-1:0] h;
        t_cmd              c;
        if ($urandom_range(0, 99) < 80)
            lk = hot_lock[$urandom_range(0, 3)];
        else
            lk = LOCK_W'($urandom_range(0, LOCK_COUNT - 1));
        c = ($urandom_range(0, 99) < acq_weight) ? CMD_ACQUIRE : CMD_RELEASE;
        h = HOST_W'($urandom_range(0, HOST_COUNT - 1));
        if (c == CMD_ACQUIRE && board.mode[lk] == MODE_RETRYING && $urandom_range(0, 1))
            h = board.invited[lk];
        else if (c == CMD_RELEASE && board.mode[lk] != MODE_FREE
                 && $urandom_range(0, 9) < 6)
            h = board.holder[lk];
        send_request(c, lk, h);
    endtask

    // reply side: random stalls, check every beat
    initial begin
        int gap;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = snk_idle ? $urandom_range(0, 15) : 0;
            if (gap > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_ch.valid) @(posedge i_clk);
            board.check_reply(rsp_ch.reply_status, rsp_ch.message_kind,
                              rsp_ch.message_host);
        end
    end

    // reset, stimulus and end of run
    initial begin
        board                 = new();
        src_idle              = 1'b0;
        snk_idle              = 1'b0;
        acq_weight            = 60;
        i_rst_n              <= 1'b0;
        req_ch.valid          <= 1'b0;
        req_ch.command        <= CMD_ACQUIRE;
        req_ch.lock_index     <= '0;
        req_ch.requester_host <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // grant, revoke, fill the queue to overflow on lock 0
        send_request(CMD_ACQUIRE, 6'd0, 4'd0);
        send_request(CMD_ACQUIRE, 6'd0, 4'd15);
        for (int i = 1; i <= 7; i++)
            send_request(CMD_ACQUIRE, 6'd0, HOST_W'(i));
        send_request(CMD_ACQUIRE, 6'd0, 4'd8);
        // hand-off, full queue while retrying, invited host takes it back
        send_request(CMD_RELEASE, 6'd0, 4'd0);
        send_request(CMD_ACQUIRE, 6'd0, 4'd9);
        send_request(CMD_ACQUIRE, 6'd0, 4'd10);
        send_request(CMD_ACQUIRE, 6'd0, 4'd15);
        send_request(CMD_RELEASE, 6'd0, 4'd15);
        send_request(CMD_RELEASE, 6'd0, 4'd3);
        // short path on lock 63: invited host with empty queue, then free
        send_request(CMD_ACQUIRE, 6'd63, 4'd15);
        send_request(CMD_ACQUIRE, 6'd63, 4'd0);
        send_request(CMD_RELEASE, 6'd63, 4'd15);
        send_request(CMD_ACQUIRE, 6'd63, 4'd0);
        send_request(CMD_RELEASE, 6'd63, 4'd0);
        send_request(CMD_RELEASE, 6'd63, 4'd5);

        // random traffic in phases of varying pressure
        for (int n = 0; n < 1350; n++) begin
            if (n % 50 == 0) begin
                src_idle = ($urandom_range(0, 3) != 0);
                snk_idle = ($urandom_range(0, 3) != 0);
                case ($urandom_range(0, 2))
                    0:       acq_weight = 50;
                    1:       acq_weight = 65;
                    default: acq_weight = 80;
                endcase
            end
            if (n % 200 == 0) begin
                for (int k = 0; k < 4; k++)
                    hot_lock[k] = LOCK_W'($urandom_range(0, LOCK_COUNT - 1));
            end
            send_random();
        end
        req_ch.valid <= 1'b0;

        // drain and let any stray reply show up
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
